// ----- hw/rtl/fpars_pkg.sv -----
// ----------------------------------------------------------------------------
// fpars_pkg
// Shared widths and request codes for the binary indexed tree sum unit.
// ----------------------------------------------------------------------------
package fpars_pkg;

   localparam int POS_W  = 10;  // position field width
   localparam int SIZE_W = 11;  // slot count register width
   localparam int CNT_W  = 12;  // tree walk index, holds up to twice the slot count
   localparam int DATA_W = 32;  // node and sum width

   typedef enum logic {
      REQ_ADD   = 1'b0,
      REQ_QUERY = 1'b1
   } req_code_type;

endpackage

// ----- hw/rtl/fpars_if.sv -----
// ----------------------------------------------------------------------------
// fpars request and response channels
// Valid/ready channels carrying add/query beats in and range sums out.
// ----------------------------------------------------------------------------
interface fpars_req_if
   import fpars_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic        [POS_W-1:0]  first_index;
   logic        [POS_W-1:0]  last_index;
   logic signed [DATA_W-1:0] delta;

   modport source (output valid, req_type, first_index, last_index, delta, input ready);
   modport sink   (input valid, req_type, first_index, last_index, delta, output ready);
endinterface

interface fpars_rsp_if
   import fpars_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] range_sum;

   modport source (output valid, range_sum, input ready);
   modport sink   (input valid, range_sum, output ready);
endinterface

// ----- hw/rtl/fenwick_point_add_range_sum_unit.sv -----
// ----------------------------------------------------------------------------
// fenwick_point_add_range_sum_unit
// Binary indexed tree of wrapped 32-bit sums: point add and inclusive range sum.
// ----------------------------------------------------------------------------
// After reset the unit zeroes every node of the memory and holds
// req_bus.ready low meanwhile; csr writes are taken at any time. It works
// on one request at a time through a single-port node memory and one shared
// index/data step unit. An add beat takes an accept step, then a read and a
// write-back for each node on its upward walk, then a closing step; an add
// at position 0 visits 11 nodes for 1024 slots.
// A query walks prefix(last+1) and then prefix(first), issuing one node read
// per cycle with the accumulate of each read in the following cycle: an
// accept step, up to 10 node reads per prefix for 1024 slots, a phase switch,
// a drain, a closing step and a result step, which waits while the output
// register is still held. A finished sum waits in an output register, so a
// new beat is taken while the previous result is still held.
// ----------------------------------------------------------------------------
module fenwick_point_add_range_sum_unit
   import fpars_pkg::*;
#(
   parameter int MAX_SLOTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [SIZE_W-1:0] csr_wdata,
   fpars_req_if.sink         req_bus,
   fpars_rsp_if.source       rsp_bus
);

   localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ADD_RD,
      S_ADD_WR,
      S_Q_WALK,
      S_Q_DONE
   } state_type;

   // Sequencer and datapath registers
   state_type         state_ff,    state_in;
   logic [SIZE_W-1:0] size_ff,     size_in;
   logic [AW-1:0]     clr_ff,      clr_in;
   logic [CNT_W-1:0]  idx_ff,      idx_in;
   logic [CNT_W-1:0]  lim_ff,      lim_in;   // add: slot count; query: second prefix
   logic [DATA_W-1:0] delta_ff,    delta_in;
   logic [DATA_W-1:0] acc_ff,      acc_in;
   logic              phase_ff,    phase_in; // 0: upper prefix, 1: lower prefix
   logic              pend_ff,     pend_in;  // a node read lands this cycle
   logic              pend_sub_ff, pend_sub_in;
   logic              rsp_vld_ff,  rsp_vld_in;
   logic [DATA_W-1:0] rsp_sum_ff,  rsp_sum_in;

   logic [SIZE_W-1:0] n_eff;
   logic [SIZE_W-1:0] hi_raw, hi_clamp, lo_clamp;
   logic [CNT_W-1:0]  idx_dec;
   logic [CNT_W-1:0]  alu_idx_next;
   logic [DATA_W-1:0] alu_sum;
   logic              alu_up;
   logic [DATA_W-1:0] alu_a;
   logic              alu_sub;
   logic              ram_we;
   logic [AW-1:0]     ram_addr;
   logic [DATA_W-1:0] ram_wdata;
   logic [DATA_W-1:0] ram_rdata;
   logic              req_take;

   // Effective slot count: the register bounded by the memory depth
   always_comb begin
      n_eff    = (32'(size_ff) > MAX_SLOTS) ? SIZE_W'(MAX_SLOTS) : size_ff;
      hi_raw   = SIZE_W'(req_bus.last_index) + SIZE_W'(1);
      hi_clamp = (hi_raw > n_eff) ? n_eff : hi_raw;
      lo_clamp = (SIZE_W'(req_bus.first_index) > n_eff) ? n_eff
                                                         : SIZE_W'(req_bus.first_index);
      idx_dec  = idx_ff - CNT_W'(1);
   end

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign req_take          = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid     = rsp_vld_ff;
   assign rsp_bus.range_sum = rsp_sum_ff;

   // Shared step unit: upward index step and node update while adding,
   // downward step and accumulate while querying
   assign alu_up  = (state_ff == S_ADD_WR);
   assign alu_a   = (state_ff == S_ADD_WR) ? delta_ff : acc_ff;
   assign alu_sub = (state_ff == S_ADD_WR) ? 1'b0 : pend_sub_ff;

   fpars_walk_alu u_alu (
      .idx      (idx_ff),
      .idx_up   (alu_up),
      .op_a     (alu_a),
      .op_b     (ram_rdata),
      .op_sub   (alu_sub),
      .idx_next (alu_idx_next),
      .sum      (alu_sum)
   );

   fpars_node_ram #(
      .DEPTH (MAX_SLOTS),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      size_in     = csr_we ? csr_wdata : size_ff;
      clr_in      = clr_ff;
      idx_in      = idx_ff;
      lim_in      = lim_ff;
      delta_in    = delta_ff;
      acc_in      = acc_ff;
      phase_in    = phase_ff;
      pend_in     = 1'b0;
      pend_sub_in = pend_sub_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_sum_in  = rsp_sum_ff;
      ram_we      = 1'b0;
      ram_addr    = AW'(idx_dec);
      ram_wdata   = alu_sum;

      // Drop the held result once the sink takes it
      if (rsp_vld_ff && rsp_bus.ready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               if (req_bus.req_type == REQ_ADD) begin
                  // Positions past the slot count leave the tree alone
                  if (SIZE_W'(req_bus.first_index) < n_eff) begin
                     idx_in   = CNT_W'(req_bus.first_index) + CNT_W'(1);
                     lim_in   = CNT_W'(n_eff);
                     delta_in = req_bus.delta;
                     state_in = S_ADD_RD;
                  end
               end else begin
                  idx_in   = CNT_W'(hi_clamp);
                  lim_in   = CNT_W'(lo_clamp);
                  acc_in   = '0;
                  phase_in = 1'b0;
                  state_in = S_Q_WALK;
               end
            end
         end
         S_ADD_RD: begin
            if (idx_ff > lim_ff) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_ADD_WR;
            end
         end
         S_ADD_WR: begin
            ram_we   = 1'b1;
            idx_in   = alu_idx_next;
            state_in = S_ADD_RD;
         end
         S_Q_WALK: begin
            // Accumulate the node read issued last cycle
            if (pend_ff) begin
               acc_in = alu_sum;
            end
            if (idx_ff != '0) begin
               idx_in      = alu_idx_next;
               pend_in     = 1'b1;
               pend_sub_in = phase_ff;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               idx_in   = lim_ff;
            end else if (!pend_ff) begin
               state_in = S_Q_DONE;
            end
         end
         S_Q_DONE: begin
            // Hold until the output register is free
            if (!rsp_vld_ff || rsp_bus.ready) begin
               rsp_vld_in = 1'b1;
               rsp_sum_in = acc_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         size_ff     <= SIZE_W'(1024);
         clr_ff      <= '0;
         phase_ff    <= 1'b0;
         pend_ff     <= 1'b0;
         pend_sub_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         size_ff     <= size_in;
         clr_ff      <= clr_in;
         phase_ff    <= phase_in;
         pend_ff     <= pend_in;
         pend_sub_ff <= pend_sub_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      idx_ff     <= idx_in;
      lim_ff     <= lim_in;
      delta_ff   <= delta_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

`ifndef SYNTHESIS
   // Memory is only written by the clearing pass or an add write-back
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_ADD_WR))
      else $error("node write outside clear or add");

   // An add write-back targets a node inside the active slots
   a_add_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD_WR) |-> (idx_ff != '0 && idx_ff <= lim_ff))
      else $error("add walk left the active slots");

   // A query result is loaded only after the last node read has landed
   a_q_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_DONE) |-> (!pend_ff && phase_ff))
      else $error("query finished with a read outstanding");

   // A loaded result comes straight from the finished query
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_DONE && (!rsp_vld_ff || rsp_bus.ready)) |=>
         (rsp_vld_ff && rsp_sum_ff == $past(acc_ff)))
      else $error("result register not loaded from accumulator");
`endif

endmodule

// ----- hw/rtl/fpars_node_ram.sv -----
// ----------------------------------------------------------------------------
// fpars_node_ram
// Single-port node store with registered read data.
// ----------------------------------------------------------------------------
module fpars_node_ram
   import fpars_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/fpars_walk_alu.sv -----
// ----------------------------------------------------------------------------
// fpars_walk_alu
// Shared step unit: tree index step by lowest set bit, and 32-bit add/sub.
// ----------------------------------------------------------------------------
module fpars_walk_alu
   import fpars_pkg::*;
(
   input  logic [CNT_W-1:0]  idx,
   input  logic              idx_up,
   input  logic [DATA_W-1:0] op_a,
   input  logic [DATA_W-1:0] op_b,
   input  logic              op_sub,
   output logic [CNT_W-1:0]  idx_next,
   output logic [DATA_W-1:0] sum
);

   logic [CNT_W-1:0] low_bit;

   always_comb begin
      low_bit  = idx & (~idx + CNT_W'(1));
      idx_next = idx_up ? (idx + low_bit) : (idx - low_bit);
      sum      = op_sub ? (op_a - op_b) : (op_a + op_b);
   end

endmodule

// ----- bench/tb_fenwick_point_add_range_sum_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fenwick_point_add_range_sum_unit
// Self-checking bench for the binary indexed tree sum unit. It drives point
// adds and range queries over several slot-count settings, keeps its own copy
// of the tree, predicts every range sum, and compares each response beat in
// order. Both channels idle in random bursts except in the closing phase.
// ----------------------------------------------------------------------------
module tb_fenwick_point_add_range_sum_unit;
   import fpars_pkg::*;

   localparam int MAX_SLOTS   = 1024;
   localparam int WALK_CYCLES = 40;    // covers the longest add or query walk
   localparam int STALL_LIMIT = 4000;  // covers the post-reset clearing pass

   typedef struct packed {
      req_code_type      kind;
      logic [POS_W-1:0]  first;
      logic [POS_W-1:0]  last;
      logic [DATA_W-1:0] delta;
   } beat_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [SIZE_W-1:0] csr_wdata;

   fpars_req_if req_if ();
   fpars_rsp_if rsp_if ();

   fenwick_point_add_range_sum_unit #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if)
   );

   // Beats waiting to be driven, and range sums waiting to come back.
   beat_type          beat_queue[$];
   logic [DATA_W-1:0] pending_sums[$];

   // Bench-side copy of the node store and the slot count register.
   logic [DATA_W-1:0] bit_tree[MAX_SLOTS];
   logic [SIZE_W-1:0] slot_count;

   int   fail_count;
   int   quiet_cycles;
   int   send_gap;
   int   stall_left;
   bit   req_taken;
   bit   steady_tail;  // set for the closing phase: no idling on either side

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Clamp the register to the store depth.
   function automatic int unsigned usable_slots();
      return (slot_count > MAX_SLOTS) ? MAX_SLOTS : slot_count;
   endfunction

   // Sum of the first count slots; strip the lowest set bit per step.
   function automatic logic [DATA_W-1:0] prefix_total(int unsigned count);
      logic [DATA_W-1:0] acc;
      int unsigned       node;
      acc  = '0;
      node = count;
      while (node > 0) begin
         acc  = acc + bit_tree[node - 1];
         node = node & (node - 1);
      end
      return acc;
   endfunction

   // Walk upward from the position; an add at or past the size is dropped.
   function automatic void apply_point_add(logic [POS_W-1:0] pos, logic [DATA_W-1:0] amount);
      int unsigned limit;
      int unsigned node;
      limit = usable_slots();
      if (pos >= limit) return;
      for (node = pos + 1; node <= limit; node = node + (node & (~node + 1)))
         bit_tree[node - 1] = bit_tree[node - 1] + amount;
   endfunction

   // prefix(last+1) minus prefix(first), both lengths clamped to the size;
   // a reversed range gives the same wrapped difference.
   function automatic logic [DATA_W-1:0] predict_range_sum(logic [POS_W-1:0] first,
                                                            logic [POS_W-1:0] last);
      int unsigned limit;
      int unsigned upper;
      int unsigned lower;
      limit = usable_slots();
      upper = (last + 1 > limit) ? limit : last + 1;
      lower = (first > limit) ? limit : first;
      return prefix_total(upper) - prefix_total(lower);
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      $display("[%0t] mismatch: %s: got %h want %h", $time, what, got, want);
      fail_count++;
   endtask

   // -------------------------------------------------------------------------
   // Monitor: sample both channels and the register port at the rising edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watch_bus
      bit                rsp_taken;
      logic [DATA_W-1:0] want;
      if (reset) begin
         req_taken    = 1'b0;
         quiet_cycles = 0;
         slot_count   = MAX_SLOTS;
         foreach (bit_tree[k]) bit_tree[k] = '0;
      end else begin
         req_taken = req_if.valid && req_if.ready;
         rsp_taken = rsp_if.valid && rsp_if.ready;
         if (csr_we) slot_count = csr_wdata;
         // Fold each accepted beat into the model; a query queues its sum.
         if (req_taken) begin
            if (req_if.req_type == REQ_ADD)
               apply_point_add(req_if.first_index, req_if.delta);
            else
               pending_sums.push_back(predict_range_sum(req_if.first_index,
                                                        req_if.last_index));
         end
         // Match each response beat against the oldest predicted sum.
         if (rsp_taken) begin
            if (pending_sums.size() == 0) begin
               report_mismatch("range_sum with no query pending", rsp_if.range_sum, 'x);
            end else begin
               want = pending_sums.pop_front();
               if (rsp_if.range_sum !== want)
                  report_mismatch("range_sum", rsp_if.range_sum, want);
            end
         end
         // Watchdog: end the run after too long without any beat moving.
         if (req_taken || rsp_taken) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request driver: change at the falling edge, hold a beat until it is taken
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      beat_type beat;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap     <= 0;
      end else if (!(req_if.valid && !req_taken)) begin
         if (send_gap > 0) begin
            req_if.valid <= 1'b0;
            send_gap     <= send_gap - 1;
         end else if (beat_queue.size() > 0) begin
            beat = beat_queue.pop_front();
            req_if.req_type    <= beat.kind;
            req_if.first_index <= beat.first;
            req_if.last_index  <= beat.last;
            req_if.delta       <= beat.delta;
            req_if.valid       <= 1'b1;
            // Now and then idle after this beat.
            if (!steady_tail && $urandom_range(0, 5) == 0)
               send_gap <= $urandom_range(1, 13);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response ready: stall in random bursts.
   always @(negedge clock) begin
      if (reset || steady_tail) begin
         rsp_if.ready <= 1'b1;
         stall_left   <= 0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 12);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   task automatic queue_beat(req_code_type kind, logic [POS_W-1:0] first,
                             logic [POS_W-1:0] last, logic [DATA_W-1:0] delta);
      beat_type beat;
      beat.kind  = kind;
      beat.first = first;
      beat.last  = last;
      beat.delta = delta;
      beat_queue.push_back(beat);
   endtask

   // Wait until every beat is taken and every sum is back, then let any
   // trailing add walk finish.
   task automatic drain_block();
      while (beat_queue.size() != 0 || req_if.valid || pending_sums.size() != 0)
         @(negedge clock);
      repeat (WALK_CYCLES) @(negedge clock);
   endtask

   task automatic write_slot_count(logic [SIZE_W-1:0] value);
      drain_block();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly positions inside the live size, the rest anywhere in the field.
   function automatic logic [POS_W-1:0] pick_index(int unsigned span);
      if (span > 0 && $urandom_range(0, 3) != 0) return POS_W'($urandom_range(0, span - 1));
      return POS_W'($urandom_range(0, (1 << POS_W) - 1));
   endfunction

   function automatic logic [DATA_W-1:0] pick_delta();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 16) - 8;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_random_beats(int count, int unsigned span);
      logic [POS_W-1:0] a;
      logic [POS_W-1:0] b;
      for (int k = 0; k < count; k++) begin
         a = pick_index(span);
         b = pick_index(span);
         if ($urandom_range(0, 99) < 45) begin
            queue_beat(REQ_ADD, a, b, pick_delta());
         end else if (a > b && $urandom_range(0, 7) != 0) begin
            // keep most ranges ordered; let a few run backward
            queue_beat(REQ_QUERY, b, a, pick_delta());
         end else begin
            queue_beat(REQ_QUERY, a, b, pick_delta());
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Run: reset, directed beats, random phases, closing check
   // -------------------------------------------------------------------------
   initial begin : run_stimulus
      logic [SIZE_W-1:0] size_pick;
      int unsigned       span;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.req_type    = REQ_ADD;
      req_if.first_index = '0;
      req_if.last_index  = '0;
      req_if.delta       = '0;
      rsp_if.ready       = 1'b0;
      steady_tail        = 1'b0;
      fail_count         = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Full size from reset: field extremes, ignored fields set, full and
      // single-slot ranges, a backward range.
      queue_beat(REQ_ADD,   0,    1023, 32'h7FFF_FFFF);
      queue_beat(REQ_ADD,   1023, 0,    32'h8000_0000);
      queue_beat(REQ_ADD,   512,  7,    32'hFFFF_FFFF);
      queue_beat(REQ_ADD,   511,  0,    32'h0000_0001);
      queue_beat(REQ_QUERY, 0,    1023, 32'h5A5A_A5A5);
      queue_beat(REQ_QUERY, 0,    0,    32'h0);
      queue_beat(REQ_QUERY, 1023, 1023, 32'hFFFF_FFFF);
      queue_beat(REQ_QUERY, 1,    1022, 32'h0);
      queue_beat(REQ_QUERY, 900,  3,    32'h0);
      queue_beat(REQ_QUERY, 512,  512,  32'h0);

      // Smallest size: an add past the end is dropped, query lengths clamp.
      write_slot_count(1);
      queue_beat(REQ_ADD,   0,    0,    32'd100);
      queue_beat(REQ_ADD,   1,    0,    32'd55);
      queue_beat(REQ_QUERY, 0,    1023, 32'h0);
      queue_beat(REQ_QUERY, 1023, 1023, 32'h0);

      // Zero size: adds do nothing and every query answers zero.
      write_slot_count(0);
      queue_beat(REQ_ADD,   0,    0,    32'd9);
      queue_beat(REQ_QUERY, 0,    1023, 32'h0);

      // Register above the store depth: the walk stops at the depth.
      write_slot_count(2047);
      queue_beat(REQ_ADD,   1023, 0,    32'd3);
      queue_beat(REQ_QUERY, 0,    1023, 32'h0);
      queue_beat(REQ_QUERY, 1000, 1023, 32'h0);

      // Shrink after adds: old nodes stay and are walked under the new size.
      write_slot_count(700);
      queue_beat(REQ_ADD,   699,  0,    32'hFFFF_FFFB);
      queue_beat(REQ_ADD,   700,  0,    32'd8);
      queue_beat(REQ_QUERY, 0,    1023, 32'h0);
      queue_beat(REQ_QUERY, 600,  699,  32'h0);

      // Random phases, one size setting each; the sender pauses for all
      // sums before every register write. No idling in the last phase.
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: size_pick = 1024;
            1: size_pick = 9;
            2: size_pick = 1;
            3: size_pick = 2047;
            4: size_pick = SIZE_W'($urandom_range(0, 2047));
            5: size_pick = 300;
            6: size_pick = 0;
            default: size_pick = 1024;
         endcase
         write_slot_count(size_pick);
         if (p == 7) steady_tail = 1'b1;
         span = (size_pick > MAX_SLOTS) ? MAX_SLOTS : size_pick;
         queue_random_beats(140, span);
      end

      drain_block();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
